// File: hw/rtl/dtec_pkg.sv
// shared constants, types and functions of the datetime to elapsed count block
`default_nettype none

package dtec_pkg;

   localparam logic [16:0] FixedCenturyDays = 17'd36525;
   localparam logic [11:0] Year1900         = 12'd1900;
   localparam logic [11:0] Year2000         = 12'd2000;
   // leap years counted from year 1 up to and including 1899 and 1999
   localparam logic [16:0] Leaps1899        = 17'd460;
   localparam logic [16:0] Leaps1999        = 17'd484;
   localparam logic [8:0]  DaysPerYear      = 9'd365;
   localparam logic [12:0] Recip100         = 13'd5243;
   localparam logic [3:0]  MonthMarch       = 4'd3;
   localparam logic [10:0] CenturyReset     = 11'd2000;
   localparam logic [5:0]  RoundSecond      = 6'd30;

   typedef struct packed {
      logic [16:0] tod_sec;
      logic [10:0] tod_min;
      logic [4:0]  tod_hr;
   } tod_type;

   // floor(x / 100) by reciprocal, exact over the whole 12-bit range
   function automatic logic [5:0] div100(input logic [11:0] x);
      logic [24:0] prod;
      prod = {13'd0, x} * {12'd0, Recip100};
      return prod[24:19];
   endfunction

   // days in the months before month m of a common year, months above 12 count 31
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         4'd13:   d = 9'd365;
         4'd14:   d = 9'd396;
         4'd15:   d = 9'd427;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dtec_day_pipe.sv
// three-stage day count pipeline: year quotients, year and month parts, final sum
`default_nettype none

module dtec_day_pipe (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [11:0]       in_year,
   input  wire logic [3:0]        in_month,
   input  wire logic [4:0]        in_day,
   input  wire dtec_pkg::tod_type in_tod,
   output logic                   out_valid,
   output logic [16:0]            out_days,
   output dtec_pkg::tod_type      out_tod
);

   // stage a: quotients by 100
   logic              a_valid_ff;
   logic [11:0]       a_year_ff;
   logic [5:0]        a_q_ff;
   logic [5:0]        a_qm1_ff;
   logic [3:0]        a_month_ff;
   logic [4:0]        a_day_ff;
   dtec_pkg::tod_type a_tod_ff;
   logic [5:0]        a_q_in;
   logic [5:0]        a_qm1_in;

   assign a_q_in   = dtec_pkg::div100(in_year);
   assign a_qm1_in = dtec_pkg::div100(in_year - 12'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_year_ff  <= in_year;
      a_q_ff     <= a_q_in;
      a_qm1_ff   <= a_qm1_in;
      a_month_ff <= in_month;
      a_day_ff   <= in_day;
      a_tod_ff   <= in_tod;
   end

   // stage b: whole years and days within the year
   logic              b_valid_ff;
   logic [16:0]       b_year_days_ff;
   logic [16:0]       b_month_days_ff;
   dtec_pkg::tod_type b_tod_ff;
   logic [16:0]       b_year_days_in;
   logic [16:0]       b_month_days_in;
   logic [11:0]       ym1;
   logic [16:0]       leaps_to;
   logic [11:0]       q_times_100;
   logic              is_leap;
   logic [11:0]       n_years;
   logic [16:0]       base_days;
   logic [16:0]       leaps_from;
   logic [20:0]       n_days;

   always_comb begin
      ym1         = a_year_ff - 12'd1;
      leaps_to    = {7'd0, ym1[11:2]} - {11'd0, a_qm1_ff} + {13'd0, a_qm1_ff[5:2]};
      q_times_100 = {a_q_ff, 6'd0} + {1'b0, a_q_ff, 5'd0} + {4'd0, a_q_ff, 2'd0};
      is_leap     = (a_year_ff[1:0] == 2'd0)
                    && ((q_times_100 != a_year_ff) || (a_q_ff[1:0] == 2'd0));
      if (a_year_ff >= dtec_pkg::Year2000) begin
         n_years    = a_year_ff - dtec_pkg::Year2000;
         base_days  = dtec_pkg::FixedCenturyDays;
         leaps_from = dtec_pkg::Leaps1999;
      end else if (a_year_ff >= dtec_pkg::Year1900) begin
         n_years    = a_year_ff - dtec_pkg::Year1900;
         base_days  = 17'd0;
         leaps_from = dtec_pkg::Leaps1899;
      end else begin
         n_years    = 12'd0;
         base_days  = 17'd0;
         leaps_from = leaps_to;
      end
      n_days          = {9'd0, n_years} * {12'd0, dtec_pkg::DaysPerYear};
      b_year_days_in  = base_days + n_days[16:0] + leaps_to - leaps_from;
      b_month_days_in = {8'd0, dtec_pkg::days_before_month(a_month_ff)}
                        + {16'd0, is_leap && (a_month_ff >= dtec_pkg::MonthMarch)}
                        + {12'd0, a_day_ff} - 17'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_year_days_ff  <= b_year_days_in;
      b_month_days_ff <= b_month_days_in;
      b_tod_ff        <= a_tod_ff;
   end

   // stage c: day count, wraps at 17 bits
   logic              c_valid_ff;
   logic [16:0]       c_days_ff;
   dtec_pkg::tod_type c_tod_ff;
   logic [16:0]       c_days_in;

   assign c_days_in = b_year_days_ff + b_month_days_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_days_ff <= c_days_in;
      c_tod_ff  <= b_tod_ff;
   end

   assign out_valid = c_valid_ff;
   assign out_days  = c_days_ff;
   assign out_tod   = c_tod_ff;

endmodule

`default_nettype wire

// File: hw/rtl/datetime_to_elapsed_count_top.sv
// top level: calendar datetime to elapsed day, second, minute and hour counts
//
//   channel   ports                      transfer when
//   request   start, busy, req_*         start high and busy low
//   response  rsp_strobe, rsp_*          rsp_strobe high, one cycle, no back-pressure
//   csr       csr_valid, csr_ready, data csr_valid and csr_ready high
//
// one datetime per cycle; each result passes from its request transfer to the
// result ports through these registers in order
// (input register, three day count stages, multiply stage, output add stage)
// busy and csr_ready are constant, nothing in the pipeline ever stalls
// reset clears every stage valid and sets the century base to 2000
`default_nettype none

module datetime_to_elapsed_count_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_year_offset,
   input  wire logic [3:0]  req_month,
   input  wire logic [4:0]  req_day,
   input  wire logic [4:0]  req_hour,
   input  wire logic [5:0]  req_minute,
   input  wire logic [5:0]  req_second,
   output logic             rsp_strobe,
   output logic [16:0]      rsp_elapsed_days,
   output logic [33:0]      rsp_elapsed_seconds,
   output logic [27:0]      rsp_elapsed_minutes,
   output logic [21:0]      rsp_elapsed_hours,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_century_base
);

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   logic [10:0] century_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         century_ff <= dtec_pkg::CenturyReset;
      end else if (csr_valid && csr_ready) begin
         century_ff <= csr_century_base;
      end
   end

   // input stage
   logic        s1_valid_ff;
   logic [11:0] s1_year_ff;
   logic [3:0]  s1_month_ff;
   logic [4:0]  s1_day_ff;
   logic [4:0]  s1_hour_ff;
   logic [5:0]  s1_minute_ff;
   logic [5:0]  s1_second_ff;
   logic [11:0] s1_year_in;

   assign s1_year_in = {1'b0, century_ff} + {4'd0, req_year_offset};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_year_ff   <= s1_year_in;
      s1_month_ff  <= req_month;
      s1_day_ff    <= req_day;
      s1_hour_ff   <= req_hour;
      s1_minute_ff <= req_minute;
      s1_second_ff <= req_second;
   end

   // time of day in each unit, rounding the minute up past half a minute
   dtec_pkg::tod_type s1_tod;
   logic [16:0]       hour_secs;
   logic [16:0]       min_secs;
   logic [10:0]       hour_mins;

   always_comb begin
      hour_secs = {12'd0, s1_hour_ff} * 17'd3600;
      min_secs  = {11'd0, s1_minute_ff} * 17'd60;
      hour_mins = {6'd0, s1_hour_ff} * 11'd60;
      s1_tod.tod_sec = hour_secs + min_secs + {11'd0, s1_second_ff};
      s1_tod.tod_min = hour_mins + {5'd0, s1_minute_ff}
                       + {10'd0, s1_second_ff > dtec_pkg::RoundSecond};
      s1_tod.tod_hr  = s1_hour_ff;
   end

   logic              dp_valid;
   logic [16:0]       dp_days;
   dtec_pkg::tod_type dp_tod;

   dtec_day_pipe u_day_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_year   (s1_year_ff),
      .in_month  (s1_month_ff),
      .in_day    (s1_day_ff),
      .in_tod    (s1_tod),
      .out_valid (dp_valid),
      .out_days  (dp_days),
      .out_tod   (dp_tod)
   );

   // multiply stage
   logic              s5_valid_ff;
   logic [16:0]       s5_days_ff;
   logic [33:0]       s5_secs_ff;
   logic [27:0]       s5_mins_ff;
   logic [21:0]       s5_hours_ff;
   dtec_pkg::tod_type s5_tod_ff;
   logic [33:0]       s5_secs_in;
   logic [27:0]       s5_mins_in;
   logic [21:0]       s5_hours_in;

   assign s5_secs_in  = {17'd0, dp_days} * 34'd86400;
   assign s5_mins_in  = {11'd0, dp_days} * 28'd1440;
   assign s5_hours_in = {5'd0, dp_days} * 22'd24;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= dp_valid;
      end
      s5_days_ff  <= dp_days;
      s5_secs_ff  <= s5_secs_in;
      s5_mins_ff  <= s5_mins_in;
      s5_hours_ff <= s5_hours_in;
      s5_tod_ff   <= dp_tod;
   end

   // output stage
   logic        s6_valid_ff;
   logic [16:0] s6_days_ff;
   logic [33:0] s6_secs_ff;
   logic [27:0] s6_mins_ff;
   logic [21:0] s6_hours_ff;
   logic [33:0] s6_secs_in;
   logic [27:0] s6_mins_in;
   logic [21:0] s6_hours_in;

   assign s6_secs_in  = s5_secs_ff + {17'd0, s5_tod_ff.tod_sec};
   assign s6_mins_in  = s5_mins_ff + {17'd0, s5_tod_ff.tod_min};
   assign s6_hours_in = s5_hours_ff + {17'd0, s5_tod_ff.tod_hr};

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_days_ff  <= s5_days_ff;
      s6_secs_ff  <= s6_secs_in;
      s6_mins_ff  <= s6_mins_in;
      s6_hours_ff <= s6_hours_in;
   end

   assign rsp_strobe          = s6_valid_ff;
   assign rsp_elapsed_days    = s6_days_ff;
   assign rsp_elapsed_seconds = s6_secs_ff;
   assign rsp_elapsed_minutes = s6_mins_ff;
   assign rsp_elapsed_hours   = s6_hours_ff;

endmodule

`default_nettype wire
